>>> rtl/core/mrrc_pkg.sv
// Shared types, constants and the CRC-16 byte fold for the read response checker.
// No dependencies; every other file in rtl/core imports this package.
package mrrc_pkg;

  // Frame buffer and register limits
  localparam int MAX_FRAME = 256;
  localparam int MAX_REGS  = 125;
  localparam int POS_W     = $clog2(MAX_FRAME + 1);

  // Field widths
  localparam int REG_COUNT_W = 7;
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 16;

  // Protocol constants
  localparam logic [15:0]       CRC_INIT  = 16'hFFFF;
  localparam logic [15:0]       CRC_POLY  = 16'hA001;
  localparam logic [7:0]        FC_READ   = 8'h03;
  localparam logic [7:0]        FC_EXC    = 8'h80;
  localparam logic [POS_W-1:0]  MIN_FRAME = POS_W'(4);

  // Input item codes
  typedef enum logic [1:0] {
    ACT_BYTE   = 2'd0,
    ACT_END    = 2'd1,
    ACT_EXPIRE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Closing status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_RESP   = 3'd1,
    ST_TOO_SHORT = 3'd2,
    ST_CRC_BAD   = 3'd3,
    ST_EXCEPTION = 3'd4,
    ST_MALFORMED = 3'd5
  } status_t;

  // Result kinds
  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // One result item
  typedef struct packed {
    logic                   kind;
    logic [6:0]             reg_index;
    logic [WORD_W-1:0]      reg_value;
    logic [2:0]             status;
    logic [BYTE_W-1:0]      exception_code;
    logic [BYTE_W-1:0]      payload_len;
    logic                   frame_done;
  } result_t;

  // Fold one byte into the running CRC, LSB first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/mrrc_if.sv
// Valid/ready channel interfaces for received bytes and for result items.
// Depends on mrrc_pkg.
interface mrrc_rx_if;
  import mrrc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface mrrc_res_if;
  import mrrc_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [6:0]        reg_index;
  logic [WORD_W-1:0] reg_value;
  logic [2:0]        status;
  logic [BYTE_W-1:0] exception_code;
  logic [BYTE_W-1:0] payload_len;
  logic              frame_done;

  modport source (output valid, output kind, output reg_index, output reg_value,
                  output status, output exception_code, output payload_len,
                  output frame_done, input ready);
  modport sink   (input valid, input kind, input reg_index, input reg_value,
                  input status, input exception_code, input payload_len,
                  input frame_done, output ready);
endinterface

>>> rtl/core/mrrc_engine.sv
// Frame engine: holds the per-frame state and the register count, folds each
// byte into the CRC and forms word and closing status results. Uses mrrc_pkg.
module mrrc_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mrrc_pkg::REG_COUNT_W-1:0] cfg_data,
  input  logic                          step,
  input  logic [1:0]                    action,
  input  logic [mrrc_pkg::BYTE_W-1:0]   rx_byte,
  output logic                          has_res,
  output mrrc_pkg::result_t             res
);
  import mrrc_pkg::*;

  logic [REG_COUNT_W-1:0] reg_count;
  logic [POS_W-1:0]       byte_pos;
  logic [15:0]            crc_acc;
  logic [7:0]             func_byte;
  logic [7:0]             count_byte;
  logic [7:0]             high_hold;

  logic [POS_W-1:0]       byte_pos_next;
  logic [15:0]            crc_acc_next;
  logic [7:0]             func_byte_next;
  logic [7:0]             count_byte_next;
  logic [7:0]             high_hold_next;

  logic [REG_COUNT_W-1:0] cnt;
  logic [7:0]             cnt2;
  logic                   is_byte;
  logic                   absorb;
  logic [POS_W-1:0]       word_off;
  logic                   word_hit;
  logic [7:0]             plen;
  logic                   closing;
  status_t                st;
  logic [7:0]             exc;

  // Clamp the register count and double it for the byte count check
  assign cnt  = (reg_count > REG_COUNT_W'(MAX_REGS)) ? REG_COUNT_W'(MAX_REGS) : reg_count;
  assign cnt2 = {cnt, 1'b0};

  assign is_byte = (action == ACT_BYTE) || (action == ACT_END);
  assign absorb  = is_byte && (byte_pos < POS_W'(MAX_FRAME));
  assign closing = (action == ACT_END) || (action == ACT_EXPIRE);

  // Word position of a low byte: (pos - 4) / 2
  assign word_off = byte_pos - POS_W'(4);
  assign word_hit = absorb && (byte_pos >= POS_W'(4)) && !byte_pos[0] &&
                    (func_byte == FC_READ) && (count_byte == cnt2) &&
                    ({1'b0, word_off[POS_W-1:1]} < {{(POS_W-REG_COUNT_W){1'b0}}, cnt});

  // Absorb the byte into the frame state
  always_comb begin
    byte_pos_next   = byte_pos;
    crc_acc_next    = crc_acc;
    func_byte_next  = func_byte;
    count_byte_next = count_byte;
    high_hold_next  = high_hold;
    if (absorb) begin
      crc_acc_next  = crc_fold(crc_acc, rx_byte);
      byte_pos_next = byte_pos + POS_W'(1);
      if (byte_pos == POS_W'(1)) begin
        func_byte_next = rx_byte;
      end else if (byte_pos == POS_W'(2)) begin
        count_byte_next = rx_byte;
      end else if (byte_pos >= POS_W'(3) && byte_pos[0]) begin
        high_hold_next = rx_byte;
      end
    end
  end

  // Closing checks, in order, on the state after this byte
  assign plen = 8'(byte_pos_next - POS_W'(2));
  always_comb begin
    exc = '0;
    if (byte_pos_next == '0) begin
      st = ST_NO_RESP;
    end else if (byte_pos_next < MIN_FRAME) begin
      st = ST_TOO_SHORT;
    end else if (crc_acc_next != '0) begin
      st = ST_CRC_BAD;
    end else if ((func_byte_next & FC_EXC) != '0) begin
      st  = ST_EXCEPTION;
      exc = (plen >= 8'd3) ? count_byte_next : 8'd0;
    end else if (({1'b0, plen} < (9'd3 + {1'b0, cnt2})) ||
                 (func_byte_next != FC_READ) || (count_byte_next != cnt2)) begin
      st = ST_MALFORMED;
    end else begin
      st = ST_OK;
    end
  end

  // Form the result item
  always_comb begin
    res     = '0;
    has_res = 1'b0;
    if (closing) begin
      has_res            = 1'b1;
      res.kind           = KIND_STATUS;
      res.status         = st;
      res.exception_code = exc;
      res.payload_len    = (st == ST_NO_RESP || st == ST_TOO_SHORT) ? 8'd0 : plen;
      res.frame_done     = 1'b1;
    end else if (action == ACT_BYTE && word_hit) begin
      has_res       = 1'b1;
      res.kind      = KIND_WORD;
      res.reg_index = word_off[7:1];
      res.reg_value = {high_hold, rx_byte};
    end
  end

  // Hold the register count
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_count <= REG_COUNT_W'(1);
    end else if (cfg_we) begin
      reg_count <= cfg_data;
    end
  end

  // Advance or clear the frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos   <= '0;
      crc_acc    <= CRC_INIT;
      func_byte  <= '0;
      count_byte <= '0;
      high_hold  <= '0;
    end else if (step) begin
      if (closing) begin
        byte_pos   <= '0;
        crc_acc    <= CRC_INIT;
        func_byte  <= '0;
        count_byte <= '0;
        high_hold  <= '0;
      end else begin
        byte_pos   <= byte_pos_next;
        crc_acc    <= crc_acc_next;
        func_byte  <= func_byte_next;
        count_byte <= count_byte_next;
        high_hold  <= high_hold_next;
      end
    end
  end

endmodule

>>> rtl/core/mrrc_out_reg.sv
// Result register: holds one result item until the sink takes it.
// Uses mrrc_pkg and the mrrc_res_if interface.
module mrrc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mrrc_pkg::result_t data,
  output logic              free,
  mrrc_res_if.source        res
);
  import mrrc_pkg::*;

  result_t held;
  logic    valid;

  assign free = !valid || res.ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  // Load the item
  always_ff @(posedge clk) begin
    if (push) begin
      held <= data;
    end
  end

  assign res.valid          = valid;
  assign res.kind           = held.kind;
  assign res.reg_index      = held.reg_index;
  assign res.reg_value      = held.reg_value;
  assign res.status         = held.status;
  assign res.exception_code = held.exception_code;
  assign res.payload_len    = held.payload_len;
  assign res.frame_done     = held.frame_done;

endmodule

>>> rtl/core/modbus_rtu_read_response_checker.sv
// Modbus RTU read holding registers (function 03) response checker. Feed the
// response one byte per item (action 0 mid-frame, 1 for the last byte, 2 when
// the reception window expires). Each item passes from its input register
// through the combinational frame engine into the result register, so one item
// is accepted every cycle while the result register can drain.
// Register words come out as they complete and stay provisional until the
// closing status item reports ok. Write reg_count only while no frame is open.
module modbus_rtu_read_response_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mrrc_pkg::REG_COUNT_W-1:0] cfg_data,
  mrrc_rx_if.sink                          rx,
  mrrc_res_if.source                       result
);
  import mrrc_pkg::*;

  logic              in_valid;
  logic [1:0]        in_action;
  logic [BYTE_W-1:0] in_byte;
  logic              has_res;
  result_t           res_data;
  logic              out_free;
  logic              advance;
  logic              accept;

  // Move the held item on when its result, if any, has room
  assign advance  = in_valid && (!has_res || out_free);
  assign rx.ready = !in_valid || advance;
  assign accept   = rx.valid && rx.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_action <= rx.action;
      in_byte   <= rx.rx_byte;
    end
  end

  mrrc_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .step     (advance),
    .action   (in_action),
    .rx_byte  (in_byte),
    .has_res  (has_res),
    .res      (res_data)
  );

  mrrc_out_reg u_out_reg (
    .clk  (clk),
    .rst  (rst),
    .push (advance && has_res),
    .data (res_data),
    .free (out_free),
    .res  (result)
  );

endmodule
